// ----- rtl/tlca_pkg.sv -----
// shared constants, types and helpers for the lowest common ancestor block
package tlca_pkg;

    localparam int NODES      = 1024;
    localparam int LEVELS     = 10;
    localparam int NODE_W     = 10;
    localparam int DEPTH_W    = 10;
    localparam int DEPTH_MAX  = (2 ** DEPTH_W) - 1;
    localparam int DEPTH_AW   = $clog2(NODES);
    localparam int JUMP_DEPTH = NODES * LEVELS;
    localparam int JUMP_AW    = $clog2(JUMP_DEPTH);
    localparam int LVL_AW     = $clog2(LEVELS);
    localparam int K_W        = $clog2(LEVELS + 1);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [DEPTH_W-1:0]  depth_t;
    typedef logic [LVL_AW-1:0]   lvl_t;
    typedef logic [LEVELS-1:0]   diff_t;
    typedef logic [K_W-1:0]      kcnt_t;
    typedef logic [DEPTH_AW-1:0] daddr_t;
    typedef logic [JUMP_AW-1:0]  jaddr_t;

    typedef struct packed {
        logic   we;
        daddr_t waddr;
        depth_t wdata;
        daddr_t raddr;
    } depth_req_t;

    typedef struct packed {
        logic   we;
        jaddr_t waddr;
        node_t  wdata;
        jaddr_t raddr;
    } jump_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_DEP,
        ST_ADD_LVL,
        ST_Q_DA,
        ST_Q_DB,
        ST_LIFT,
        ST_LIFT_W,
        ST_CMP_B,
        ST_CMP_E,
        ST_FIN,
        ST_DONE
    } state_t;

    function automatic node_t clip_node(input node_t n);
        clip_node = (32'(n) < NODES) ? n : '0;
    endfunction

    function automatic daddr_t depth_addr(input node_t n);
        depth_addr = daddr_t'(n);
    endfunction

    function automatic jaddr_t jump_addr(input node_t n, input lvl_t k);
        jump_addr = jaddr_t'(32'(n) * LEVELS + 32'(k));
    endfunction

endpackage

// ----- rtl/tlca_ram.sv -----
// generic single write port ram with registered read
module tlca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tlca_ctrl.sv -----
// sequencer for table clearing, node insertion and ancestor queries
module tlca_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  tlca_pkg::node_t       s_node,
    input  tlca_pkg::node_t       s_other_node,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tlca_pkg::node_t       m_ancestor,
    output logic                  m_was_query,
    output tlca_pkg::depth_req_t  depth_req,
    input  tlca_pkg::depth_t      depth_rdata,
    output tlca_pkg::jump_req_t   jump_req,
    input  tlca_pkg::node_t       jump_rdata
);
    import tlca_pkg::*;

    state_t state_reg, state_next;
    jaddr_t clr_cnt_reg, clr_cnt_next;
    logic   op_reg, op_next;
    node_t  a_reg, a_next;
    node_t  b_reg, b_next;
    depth_t da_reg, da_next;
    diff_t  diff_reg, diff_next;
    kcnt_t  k_reg, k_next;
    node_t  ua_reg, ua_next;
    node_t  result_reg, result_next;
    logic   byp_hit_reg;
    node_t  byp_data_reg;
    logic   m_valid_reg, m_valid_next;
    node_t  m_ancestor_reg, m_ancestor_next;
    logic   m_was_query_reg, m_was_query_next;

    node_t  jrd;
    node_t  in_a;
    node_t  in_b;
    logic   accept;
    logic   out_free;
    logic   clr_last;
    logic   k_top;
    logic   k_zero;
    lvl_t   lvl;
    logic   swap;
    depth_t ddiff;
    depth_t dep_inc;
    logic   cmp_ne;
    node_t  a_sel;
    node_t  b_sel;

    // operand decode, handshake flags and compare helpers
    always_comb begin
        jrd      = byp_hit_reg ? byp_data_reg : jump_rdata;
        in_a     = clip_node(s_node);
        in_b     = clip_node(s_other_node);
        accept   = s_valid && s_ready;
        out_free = !m_valid_reg || m_ready;
        clr_last = (32'(clr_cnt_reg) == JUMP_DEPTH - 1);
        k_top    = (k_reg == kcnt_t'(LEVELS));
        k_zero   = (k_reg == '0);
        lvl      = lvl_t'(k_reg);
        swap     = da_reg < depth_rdata;
        ddiff    = swap ? (depth_rdata - da_reg) : (da_reg - depth_rdata);
        dep_inc  = (depth_rdata == depth_t'(DEPTH_MAX)) ? depth_rdata
                                                        : depth_rdata + depth_t'(1);
        cmp_ne   = ua_reg != jrd;
        a_sel    = cmp_ne ? ua_reg : a_reg;
        b_sel    = cmp_ne ? jrd : b_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_QUERY) begin
                        state_next = ST_Q_DA;
                    end else if (in_a != '0) begin
                        state_next = ST_ADD_DEP;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ADD_DEP: state_next = ST_ADD_LVL;
            ST_ADD_LVL: begin
                if (k_reg == kcnt_t'(LEVELS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_Q_DA: state_next = ST_Q_DB;
            ST_Q_DB: state_next = ST_LIFT;
            ST_LIFT: begin
                if (k_top) begin
                    state_next = (a_reg == b_reg) ? ST_DONE : ST_CMP_B;
                end else if (diff_reg[0]) begin
                    state_next = ST_LIFT_W;
                end
            end
            ST_LIFT_W: state_next = ST_LIFT;
            ST_CMP_B: state_next = ST_CMP_E;
            ST_CMP_E: state_next = k_zero ? ST_FIN : ST_CMP_B;
            ST_FIN: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // memory requests and handshake
    always_comb begin
        s_ready         = 1'b0;
        depth_req.we    = 1'b0;
        depth_req.waddr = depth_addr(a_reg);
        depth_req.wdata = dep_inc;
        depth_req.raddr = depth_addr(b_reg);
        jump_req.we     = 1'b0;
        jump_req.waddr  = jump_addr(a_reg, lvl);
        jump_req.wdata  = jrd;
        jump_req.raddr  = jump_addr(a_reg, lvl);
        case (state_reg)
            ST_CLEAR: begin
                depth_req.we    = 32'(clr_cnt_reg) < NODES;
                depth_req.waddr = clr_cnt_reg[DEPTH_AW-1:0];
                depth_req.wdata = '0;
                jump_req.we     = 1'b1;
                jump_req.waddr  = clr_cnt_reg;
                jump_req.wdata  = '0;
            end
            ST_IDLE: begin
                s_ready         = 1'b1;
                depth_req.raddr = depth_addr((s_op == OP_ADD) ? in_b : in_a);
            end
            ST_ADD_DEP: begin
                depth_req.we   = 1'b1;
                jump_req.we    = 1'b1;
                jump_req.waddr = jump_addr(a_reg, '0);
                jump_req.wdata = b_reg;
                jump_req.raddr = jump_addr(b_reg, '0);
            end
            ST_ADD_LVL: begin
                jump_req.we    = 1'b1;
                jump_req.raddr = jump_addr(jrd, lvl);
            end
            ST_LIFT: begin
                if (k_top) begin
                    jump_req.raddr = jump_addr(a_reg, lvl_t'(LEVELS - 1));
                end
            end
            ST_CMP_B: jump_req.raddr = jump_addr(b_reg, lvl);
            ST_CMP_E: begin
                jump_req.raddr = jump_addr(a_sel, k_zero ? '0 : lvl - lvl_t'(1));
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        clr_cnt_next     = clr_cnt_reg;
        op_next          = op_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        da_next          = da_reg;
        diff_next        = diff_reg;
        k_next           = k_reg;
        ua_next          = ua_reg;
        result_next      = result_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_ancestor_next  = m_ancestor_reg;
        m_was_query_next = m_was_query_reg;
        case (state_reg)
            ST_CLEAR: clr_cnt_next = clr_cnt_reg + jaddr_t'(1);
            ST_IDLE: begin
                if (accept) begin
                    op_next     = s_op;
                    a_next      = in_a;
                    b_next      = in_b;
                    result_next = '0;
                    k_next      = kcnt_t'(1);
                end
            end
            ST_ADD_LVL: k_next = k_reg + kcnt_t'(1);
            ST_Q_DA: da_next = depth_rdata;
            ST_Q_DB: begin
                if (swap) begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
                diff_next = diff_t'({{LEVELS{1'b0}}, ddiff});
                k_next    = '0;
            end
            ST_LIFT: begin
                if (k_top) begin
                    result_next = a_reg;
                    k_next      = kcnt_t'(LEVELS - 1);
                end else if (!diff_reg[0]) begin
                    diff_next = diff_reg >> 1;
                    k_next    = k_reg + kcnt_t'(1);
                end
            end
            ST_LIFT_W: begin
                a_next    = jrd;
                diff_next = diff_reg >> 1;
                k_next    = k_reg + kcnt_t'(1);
            end
            ST_CMP_B: ua_next = jrd;
            ST_CMP_E: begin
                a_next = a_sel;
                b_next = b_sel;
                if (!k_zero) begin
                    k_next = k_reg - kcnt_t'(1);
                end
            end
            ST_FIN: result_next = jrd;
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_ancestor_next  = result_reg;
                    m_was_query_next = op_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            byp_hit_reg <= jump_req.we && (jump_req.waddr == jump_req.raddr);
        end
        byp_data_reg     <= jump_req.wdata;
        op_reg           <= op_next;
        a_reg            <= a_next;
        b_reg            <= b_next;
        da_reg           <= da_next;
        diff_reg         <= diff_next;
        k_reg            <= k_next;
        ua_reg           <= ua_next;
        result_reg       <= result_next;
        m_ancestor_reg   <= m_ancestor_next;
        m_was_query_reg  <= m_was_query_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_ancestor  = m_ancestor_reg;
    assign m_was_query = m_was_query_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction taken while one is in flight");

    a_clear_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && !clr_last) |=>
            (state_reg == ST_CLEAR && clr_cnt_reg == $past(clr_cnt_reg) + jaddr_t'(1)))
        else $error("clearing pass skipped an entry");

    a_depth_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (depth_req.we && state_reg != ST_CLEAR) |-> depth_req.wdata != '0)
        else $error("inserted node written with depth zero");

    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=>
            (m_valid_reg && m_was_query_reg == $past(op_reg)))
        else $error("result kind does not match the transaction");

endmodule

// ----- rtl/tree_lca_binary_lifting.sv -----
// add: writes the depth and the parent entry, then fills the higher ancestor levels (node 0 is not written)
// query: reads both depths, lifts the deeper node, then, unless they meet, compares from the top level down
// the ancestor table has a single read port; one transaction at a time
// a finished result sits in the output register while the next transaction is taken
// after reset both tables are cleared entry by entry, s_ready low meanwhile
// top level: sequencer with depth and ancestor table memories
module tree_lca_binary_lifting (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_op,
    input  tlca_pkg::node_t s_node,
    input  tlca_pkg::node_t s_other_node,
    output logic            m_valid,
    input  logic            m_ready,
    output tlca_pkg::node_t m_ancestor,
    output logic            m_was_query
);
    import tlca_pkg::*;

    depth_req_t depth_req;
    jump_req_t  jump_req;
    depth_t     depth_rdata;
    node_t      jump_rdata;

    tlca_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_node       (s_node),
        .s_other_node (s_other_node),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ancestor   (m_ancestor),
        .m_was_query  (m_was_query),
        .depth_req    (depth_req),
        .depth_rdata  (depth_rdata),
        .jump_req     (jump_req),
        .jump_rdata   (jump_rdata)
    );

    tlca_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (NODES)
    ) u_depth_ram (
        .aclk  (aclk),
        .we    (depth_req.we),
        .waddr (depth_req.waddr),
        .wdata (depth_req.wdata),
        .raddr (depth_req.raddr),
        .rdata (depth_rdata)
    );

    tlca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (JUMP_DEPTH)
    ) u_jump_ram (
        .aclk  (aclk),
        .we    (jump_req.we),
        .waddr (jump_req.waddr),
        .wdata (jump_req.wdata),
        .raddr (jump_req.raddr),
        .rdata (jump_rdata)
    );

endmodule

// ----- bench/tb_tree_lca_binary_lifting.sv -----
// testbench for the binary lifting lowest common ancestor block: tree building and lca queries
module tb_tree_lca_binary_lifting;
    import tlca_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_ITEMS  = 100;
    localparam int TAIL_CYCLES  = 60;

    class lca_scoreboard;
        depth_t depth_tab [NODES];
        node_t  jump_tab [NODES][LEVELS];
        node_t  due_ancestor [$];
        logic   due_query [$];
        int     errors;

        function new();
            foreach (depth_tab[n]) depth_tab[n] = '0;
            foreach (jump_tab[n, k]) jump_tab[n][k] = '0;
            errors = 0;
        endfunction

        function int pending();
            return due_ancestor.size();
        endfunction

        function void enqueue(node_t anc, logic q);
            due_ancestor = {due_ancestor, anc};
            due_query = {due_query, q};
        endfunction

        function void note_accepted(logic op, node_t node_in, node_t other_in);
            node_t             a;
            node_t             b;
            node_t             t;
            node_t             ua;
            node_t             ub;
            node_t             lca;
            logic [DEPTH_W:0]  d;
            diff_t             gap;
            a = (int'(node_in) < NODES) ? node_in : '0;
            b = (int'(other_in) < NODES) ? other_in : '0;
            if (op == OP_ADD) begin
                if (a != '0) begin
                    d = {1'b0, depth_tab[b]} + 1'b1;
                    if (d > DEPTH_MAX) d = (DEPTH_W + 1)'(DEPTH_MAX);
                    depth_tab[a] = d[DEPTH_W-1:0];
                    jump_tab[a][0] = b;
                    for (int k = 1; k < LEVELS; k++) begin
                        jump_tab[a][k] = jump_tab[jump_tab[a][k-1]][k-1];
                    end
                end
                enqueue('0, 1'b0);
            end else begin
                if (depth_tab[a] < depth_tab[b]) begin
                    t = a;
                    a = b;
                    b = t;
                end
                gap = diff_t'(depth_tab[a] - depth_tab[b]);
                for (int k = 0; k < LEVELS; k++) begin
                    if (gap[k]) a = jump_tab[a][k];
                end
                if (a == b) begin
                    lca = a;
                end else begin
                    for (int k = LEVELS - 1; k >= 0; k--) begin
                        ua = jump_tab[a][k];
                        ub = jump_tab[b][k];
                        if (ua != ub) begin
                            a = ua;
                            b = ub;
                        end
                    end
                    lca = jump_tab[a][0];
                end
                enqueue(lca, 1'b1);
            end
        endfunction

        function void check_result(node_t ancestor, logic was_query);
            node_t exp_anc;
            logic  exp_q;
            if (due_ancestor.size() == 0) begin
                $error("result transaction with nothing pending: ancestor %0d was_query %0d",
                       ancestor, was_query);
                errors++;
            end else begin
                exp_anc = due_ancestor.pop_front();
                exp_q = due_query.pop_front();
                if (ancestor !== exp_anc) begin
                    $error("ancestor: expected %0d, actual %0d", exp_anc, ancestor);
                    errors++;
                end
                if (was_query !== exp_q) begin
                    $error("was_query: expected %0d, actual %0d", exp_q, was_query);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    node_t       s_node;
    node_t       s_other_node;
    logic        m_valid;
    logic        m_ready;
    node_t       m_ancestor;
    logic        m_was_query;

    bit               quiet;
    logic [NODES-1:0] in_phase;
    lca_scoreboard    sb = new();

    tree_lca_binary_lifting dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_node       (s_node),
        .s_other_node (s_other_node),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ancestor   (m_ancestor),
        .m_was_query  (m_was_query)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic pause(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // drive one transaction and hold it until accepted
    task automatic put(input logic op, input node_t a, input node_t b);
        if (!quiet && $urandom_range(0, 7) == 0) pause($urandom_range(1, 18));
        s_valid      <= 1'b1;
        s_op         <= op;
        s_node       <= a;
        s_other_node <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_accepted(op, a, b);
    endtask

    function automatic node_t fresh_node();
        node_t c;
        c = node_t'($urandom_range(1, NODES - 1));
        for (int tries = 0; tries < 64 && in_phase[c]; tries++) begin
            c = node_t'($urandom_range(1, NODES - 1));
        end
        in_phase[c] = 1'b1;
        return c;
    endfunction

    function automatic node_t any_node();
        return node_t'($urandom_range(0, NODES - 1));
    endfunction

    // result side with random stall bursts
    initial begin : result_side
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_ancestor, m_was_query);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        node_t members [$];
        node_t c;
        node_t p;
        node_t a;
        node_t b;
        int    count;
        int    phase;
        int    plen;
        int    roll;
        bit    chain;

        quiet = 1'b0;
        in_phase = '0;
        s_valid      <= 1'b0;
        s_op         <= OP_ADD;
        s_node       <= '0;
        s_other_node <= '0;
        aresetn      <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // empty tree, ignored add of node 0, small tree with extreme node numbers
        put(OP_QUERY, '0, '0);
        put(OP_ADD, '0, 10'd5);
        put(OP_ADD, 10'd1, '0);
        put(OP_ADD, 10'd2, 10'd1);
        put(OP_ADD, 10'd3, 10'd1);
        put(OP_ADD, 10'd4, 10'd2);
        put(OP_ADD, 10'd1023, 10'd4);
        put(OP_ADD, 10'd512, 10'd1023);
        put(OP_QUERY, 10'd4, 10'd3);
        put(OP_QUERY, 10'd1023, 10'd512);
        put(OP_QUERY, 10'd512, 10'd3);
        put(OP_QUERY, 10'd1, 10'd1);
        put(OP_QUERY, '0, 10'd1023);
        put(OP_QUERY, 10'd1023, '0);
        // parent never added, and a separate tree
        put(OP_ADD, 10'd700, 10'd900);
        put(OP_QUERY, 10'd700, 10'd900);
        put(OP_QUERY, 10'd700, 10'd1);
        put(OP_QUERY, 10'd512, 10'd700);
        // re-add a node that has descendants
        put(OP_ADD, 10'd2, 10'd3);
        put(OP_QUERY, 10'd4, 10'd3);
        put(OP_QUERY, 10'd2, 10'd3);
        put(OP_QUERY, 10'd1023, 10'd2);
        drain();

        count = 0;
        phase = 0;
        while (count < RANDOM_ITEMS) begin
            chain = (phase == 0) || ($urandom_range(0, 7) == 0);
            plen = (phase == 0) ? 620 : $urandom_range(15, 120);
            in_phase = '0;
            members.delete();
            for (int i = 0; i < plen && count < RANDOM_ITEMS; i++) begin
                quiet = (count >= RANDOM_ITEMS - QUIET_ITEMS);
                roll = $urandom_range(0, 99);
                if (members.size() == 0) begin
                    c = fresh_node();
                    p = ($urandom_range(0, 5) == 0) ? node_t'($urandom_range(1, NODES - 1)) : '0;
                    put(OP_ADD, c, p);
                    members = {members, c};
                end else if (roll < (chain ? 90 : 45)) begin
                    c = fresh_node();
                    if (chain && $urandom_range(0, 9) != 0) p = members[$];
                    else p = members[$urandom_range(0, members.size() - 1)];
                    put(OP_ADD, c, p);
                    members = {members, c};
                end else if (roll < (chain ? 98 : 90)) begin
                    a = members[$urandom_range(0, members.size() - 1)];
                    if ($urandom_range(0, 9) == 0) b = any_node();
                    else b = members[$urandom_range(0, members.size() - 1)];
                    put(OP_QUERY, a, b);
                end else begin
                    put(logic'($urandom_range(0, 1)), any_node(), any_node());
                end
                count++;
            end
            phase++;
            if (!quiet && $urandom_range(0, 3) == 0) drain();
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tlca_pkg.sv
rtl/tlca_ram.sv
rtl/tlca_ctrl.sv
rtl/tree_lca_binary_lifting.sv
bench/tb_tree_lca_binary_lifting.sv
